FILE: design/pwss_pkg.sv
// Shared types and constants for the pulse width size sorter.
// Used by the configuration, datapath, divider, controller, top and checker files.
package pwss_pkg;

    localparam int COUNT_WIDTH   = 16;
    localparam int TIMEOUT_TICKS = 3;

    localparam int KIND_W    = 3;
    localparam int CAP_W     = 16;
    localparam int SEL_W     = 16;
    localparam int CODE_W    = 3;
    localparam int WIDTH_W   = 18;
    localparam int PERIOD_W  = 17;
    localparam int LED_W     = 3;
    localparam int PCT_SCALE = 100;
    localparam int PCT_W     = $clog2(PCT_SCALE + 1);
    localparam int PROD_W    = COUNT_WIDTH + PCT_W;
    localparam int TICK_W    = $clog2(TIMEOUT_TICKS + 1);
    localparam int PW_W      = TICK_W + PERIOD_W + 2;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [WIDTH_W-1:0]  MIN_WIDTH_RST = WIDTH_W'(30000);
    localparam logic [WIDTH_W-1:0]  MAX_WIDTH_RST = WIDTH_W'(50000);
    localparam logic [PERIOD_W-1:0] PERIOD_RST    = PERIOD_W'(65536);

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_MIN_WIDTH    = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH    = 2'd1;
    localparam logic [1:0] REG_TIMER_PERIOD = 2'd2;

    // Event kinds.
    localparam logic [KIND_W-1:0] K_EDGE   = 3'd0;
    localparam logic [KIND_W-1:0] K_ONOFF  = 3'd1;
    localparam logic [KIND_W-1:0] K_ERASE  = 3'd2;
    localparam logic [KIND_W-1:0] K_Q_STD  = 3'd3;
    localparam logic [KIND_W-1:0] K_Q_OVER = 3'd4;
    localparam logic [KIND_W-1:0] K_Q_UNDR = 3'd5;
    localparam logic [KIND_W-1:0] K_Q_PCT  = 3'd6;
    localparam logic [KIND_W-1:0] K_TICK   = 3'd7;

    // Display codes.
    localparam logic [CODE_W-1:0] D_NONE    = 3'd0;
    localparam logic [CODE_W-1:0] D_STD     = 3'd1;
    localparam logic [CODE_W-1:0] D_OVER    = 3'd2;
    localparam logic [CODE_W-1:0] D_UNDER   = 3'd3;
    localparam logic [CODE_W-1:0] D_PCT     = 3'd4;
    localparam logic [CODE_W-1:0] D_TIMEOUT = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CAP_W-1:0]  capture_value;
    } t_in_beat;

    typedef struct packed {
        logic              belt_on;
        logic              item_present_led;
        logic              item_left_led;
        logic              defect_led;
        logic [SEL_W-1:0]  selected_value;
        logic [CODE_W-1:0] display_code;
    } t_out_beat;

    typedef struct packed {
        logic [WIDTH_W-1:0]  min_width;
        logic [WIDTH_W-1:0]  max_width;
        logic [PERIOD_W-1:0] timer_period;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic is_pct;
        logic div_done;
    } t_dp_stat;

endpackage

FILE: design/pwss_cfg.sv
// APB-style register file holding the width limits and the timer period.
// Depends on pwss_pkg.
module pwss_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pwss_pkg::APB_AW-1:0]  paddr,
    input  logic [pwss_pkg::APB_DW-1:0]  pwdata,
    output logic [pwss_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output pwss_pkg::t_cfg               o_cfg
);
    import pwss_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_width    <= MIN_WIDTH_RST;
            r_cfg.max_width    <= MAX_WIDTH_RST;
            r_cfg.timer_period <= PERIOD_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_WIDTH:    r_cfg.min_width    <= pwdata[WIDTH_W-1:0];
                REG_MAX_WIDTH:    r_cfg.max_width    <= pwdata[WIDTH_W-1:0];
                REG_TIMER_PERIOD: r_cfg.timer_period <= pwdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_WIDTH:    prdata = APB_DW'(r_cfg.min_width);
            REG_MAX_WIDTH:    prdata = APB_DW'(r_cfg.max_width);
            REG_TIMER_PERIOD: prdata = APB_DW'(r_cfg.timer_period);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/pwss_div.sv
// Restoring divider, one quotient bit per cycle, for the defective percentage.
// Depends on pwss_pkg.
module pwss_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [pwss_pkg::PROD_W-1:0]       i_dividend,
    input  logic [pwss_pkg::COUNT_WIDTH-1:0]  i_divisor,
    output logic                              o_done,
    output logic [pwss_pkg::PROD_W-1:0]       o_quotient
);
    import pwss_pkg::*;

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0]      r_quo;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [COUNT_WIDTH-1:0] r_dvs;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [COUNT_WIDTH:0]   trial;
    logic                   fits;

    assign trial = {r_rem, r_quo[PROD_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend bits shift out of the top while quotient bits enter at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[PROD_W-2:0], fits};
            r_rem <= fits ? COUNT_WIDTH'(trial - {1'b0, r_dvs}) : trial[COUNT_WIDTH-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: design/pwss_dp.sv
// Datapath: belt and LED state, pulse width measurement, class counters,
// selection and output register. Depends on pwss_pkg and pwss_div.
module pwss_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pwss_pkg::t_in_beat   i_in_data,
    input  pwss_pkg::t_cfg       i_cfg,
    input  pwss_pkg::t_dp_cmd    i_cmd,
    output pwss_pkg::t_dp_stat   o_stat,
    output pwss_pkg::t_out_beat  o_out_data
);
    import pwss_pkg::*;

    logic                   r_running,  n_running;
    logic                   r_await,    n_await;
    logic [CAP_W-1:0]       r_first,    n_first;
    logic [TICK_W-1:0]      r_ticks,    n_ticks;
    logic [COUNT_WIDTH-1:0] r_total,    n_total;
    logic [COUNT_WIDTH-1:0] r_std,      n_std;
    logic [COUNT_WIDTH-1:0] r_over,     n_over;
    logic [COUNT_WIDTH-1:0] r_under,    n_under;
    logic [COUNT_WIDTH-1:0] r_defect,   n_defect;
    logic [LED_W-1:0]       r_led,      n_led;
    logic [SEL_W-1:0]       r_held,     n_held;
    logic [CODE_W-1:0]      r_code,     n_code;
    logic [PROD_W-1:0]      r_prod;
    t_out_beat              r_out;

    logic [PW_W-1:0]        pulse_w;
    logic                   is_std;
    logic                   is_over;
    logic [TICK_W-1:0]      ticks_inc;
    logic                   div_done;
    logic [PROD_W-1:0]      quotient;

    pwss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    // The width is exact in PW_W bits; a negative width reads as signed below zero.
    assign pulse_w = PW_W'(i_in_data.capture_value)
                   + PW_W'(r_ticks) * PW_W'(i_cfg.timer_period)
                   - PW_W'(r_first);
    assign is_std  = ($signed(pulse_w) >= $signed(PW_W'(i_cfg.min_width)))
                  && ($signed(pulse_w) <= $signed(PW_W'(i_cfg.max_width)));
    assign is_over = $signed(pulse_w) > $signed(PW_W'(i_cfg.max_width));
    assign ticks_inc = r_ticks + 1'b1;

    always_comb begin
        n_running = r_running;
        n_await   = r_await;
        n_first   = r_first;
        n_ticks   = r_ticks;
        n_total   = r_total;
        n_std     = r_std;
        n_over    = r_over;
        n_under   = r_under;
        n_defect  = r_defect;
        n_led     = r_led;
        n_held    = r_held;
        n_code    = r_code;

        if (i_cmd.accept) begin
            n_code = D_NONE;
            case (i_in_data.kind)
                K_EDGE: begin
                    if (r_running && !r_await) begin
                        n_ticks = '0;
                        n_await = 1'b1;
                        n_first = i_in_data.capture_value;
                        n_led   = {r_led[2], 1'b0, 1'b1};
                    end else if (r_running) begin
                        n_await = 1'b0;
                        n_ticks = '0;
                        n_total = r_total + 1'b1;
                        if (is_std) begin
                            n_std = r_std + 1'b1;
                            n_led = 3'b010;
                        end else begin
                            n_defect = r_defect + 1'b1;
                            n_led    = 3'b110;
                            if (is_over) begin
                                n_over = r_over + 1'b1;
                            end else begin
                                n_under = r_under + 1'b1;
                            end
                        end
                    end
                end
                K_ONOFF: begin
                    n_running = !r_running;
                    n_led     = '0;
                end
                K_ERASE: begin
                    if (!r_running) begin
                        n_total = '0;
                    end
                end
                K_Q_STD: begin
                    n_held = SEL_W'(r_std);
                    n_code = D_STD;
                end
                K_Q_OVER: begin
                    n_held = SEL_W'(r_over);
                    n_code = D_OVER;
                end
                K_Q_UNDR: begin
                    n_held = SEL_W'(r_under);
                    n_code = D_UNDER;
                end
                K_Q_PCT: begin
                    n_code = D_PCT;
                end
                K_TICK: begin
                    if (ticks_inc >= TICK_W'(TIMEOUT_TICKS)) begin
                        n_ticks   = '0;
                        n_running = 1'b0;
                        n_led     = '0;
                        n_code    = D_TIMEOUT;
                    end else begin
                        n_ticks = ticks_inc;
                    end
                end
                default: ;
            endcase
        end

        if (div_done) begin
            if (r_total == '0) begin
                n_held = '0;
            end else if (quotient > PROD_W'(PCT_SCALE)) begin
                n_held = SEL_W'(PCT_SCALE);
            end else begin
                n_held = SEL_W'(quotient);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_await   <= 1'b0;
            r_first   <= '0;
            r_ticks   <= '0;
            r_total   <= '0;
            r_std     <= '0;
            r_over    <= '0;
            r_under   <= '0;
            r_defect  <= '0;
            r_led     <= '0;
            r_held    <= '0;
            r_code    <= D_NONE;
        end else begin
            r_running <= n_running;
            r_await   <= n_await;
            r_first   <= n_first;
            r_ticks   <= n_ticks;
            r_total   <= n_total;
            r_std     <= n_std;
            r_over    <= n_over;
            r_under   <= n_under;
            r_defect  <= n_defect;
            r_led     <= n_led;
            r_held    <= n_held;
            r_code    <= n_code;
        end
    end

    // Payload registers: the scaled defective count and the outgoing beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_prod <= PROD_W'(r_defect) * PROD_W'(PCT_SCALE);
        end
        if (i_cmd.load) begin
            r_out.belt_on          <= r_running;
            r_out.item_present_led <= r_led[0];
            r_out.item_left_led    <= r_led[1];
            r_out.defect_led       <= r_led[2];
            r_out.selected_value   <= r_held;
            r_out.display_code     <= r_code;
        end
    end

    assign o_stat.is_pct   = i_in_data.kind == K_Q_PCT;
    assign o_stat.div_done = div_done;
    assign o_out_data      = r_out;

endmodule

FILE: design/pwss_ctrl.sv
// Controller: sequences accept, percentage division and output load.
// Depends on pwss_pkg.
module pwss_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  pwss_pkg::t_dp_stat  i_stat,
    output pwss_pkg::t_dp_cmd   o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid
);
    import pwss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_start = r_state == S_DIV_GO;
        o_cmd.load      = (r_state == S_LOAD) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= i_stat.is_pct ? S_DIV_GO : S_LOAD;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (i_stat.div_done) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

FILE: design/pulse_width_size_sorter_unit.sv
// Conveyor size sorter. One result beat per input beat. For edges, buttons, count
// queries and overflow ticks the beat is taken, then its result is placed in the
// output register, and the next beat is taken in the cycle after.
// A percentage query first passes through the bit-serial divider, which forms one
// quotient bit per cycle, before its result is loaded. A stalled output holds
// the block in its load step until the waiting beat is taken.
// Depends on pwss_pkg, pwss_cfg, pwss_dp, pwss_div and pwss_ctrl.
module pulse_width_size_sorter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  pwss_pkg::t_in_beat           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output pwss_pkg::t_out_beat          o_out_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pwss_pkg::APB_AW-1:0]  paddr,
    input  logic [pwss_pkg::APB_DW-1:0]  pwdata,
    output logic [pwss_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import pwss_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    pwss_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pwss_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cfg      (cfg),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_out_data (o_out_data)
    );

    pwss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

endmodule

FILE: design/pwss_checker.sv
// Port-level checks for the size sorter, bound to the top level.
// Depends on pwss_pkg and pulse_width_size_sorter_unit.
module pwss_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  pwss_pkg::t_out_beat          o_out_data
);
    import pwss_pkg::*;

    // A stalled result beat stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    // A timeout beat shows the belt stopped and every LED dark.
    a_timeout_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.display_code == D_TIMEOUT |->
            !o_out_data.belt_on && !o_out_data.item_present_led
            && !o_out_data.item_left_led && !o_out_data.defect_led)
        else $error("timeout beat with belt or LEDs on");

    // The percentage never exceeds full scale.
    a_pct_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.display_code == D_PCT |->
            o_out_data.selected_value <= SEL_W'(PCT_SCALE))
        else $error("percentage above full scale");

    // The item-present and item-left LEDs are never lit together.
    a_led_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.item_present_led && o_out_data.item_left_led))
        else $error("present and left LEDs both lit");

    // A beat taken while no result is valid is not answered in the cycle after it is taken.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !o_out_valid |=> !o_out_valid)
        else $error("result beat appeared in the cycle after accept");

endmodule

bind pulse_width_size_sorter_unit pwss_checker u_pwss_checker (.*);
